FILE: sv/rope_pair_rotator_unit_macros.svh
// Assertion macros used by the rotary position encoding top module
`ifndef ROPE_PAIR_ROTATOR_UNIT_MACROS_SVH
`define ROPE_PAIR_ROTATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define RPR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rope pair rotator check failed");
// next-cycle implication
`define RPR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("rope pair rotator check failed");
`else
`define RPR_ASSERT_IMP(lbl, ante, cons)
`define RPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/rpr_pkg.sv
// Types, constants and the frequency table function of the rotary encoder
package rpr_pkg;

	localparam logic [30:0] ONE_Q30       = 31'd1073741824;
	localparam logic [31:0] TWO_PI_Q29    = 32'd3373259426;
	localparam logic [63:0] LOG2_1E4_Q32  = 64'd57070290109;
	localparam logic [63:0] LN2_Q32       = 64'd2977044472;
	localparam logic [12:0] KEY_WIDTH_RST = 13'd4096;
	localparam int          TRIG_TERMS    = 14;

	// angle and running sums carried through the Taylor pipeline
	typedef struct packed {
		logic [1:0]         quad;
		logic               fold;
		logic [29:0]        ang;
		logic signed [32:0] cs;
		logic signed [32:0] sn;
	} rpr_trig_t;

	// word payload riding alongside the angle
	typedef struct packed {
		logic               krot;
		logic signed [31:0] qe;
		logic signed [31:0] qo;
		logic signed [31:0] ke;
		logic signed [31:0] ko;
	} rpr_side_t;

	// restoring long division, only evaluated while the table is built
	function automatic longint unsigned rpr_udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// turns per position for one table entry, x = k*log2(1e4)/head in Q32
	function automatic logic [31:0] rpr_rate_of(input logic [63:0] x);
		longint unsigned n;
		longint unsigned f;
		longint unsigned y;
		longint unsigned term;
		longint unsigned freq;
		longint unsigned j;
		longint          sum;
		n    = x >> 32;
		f    = x & 64'hFFFF_FFFF;
		y    = (f * LN2_Q32) >> 34;
		term = 64'(ONE_Q30);
		sum  = longint'(ONE_Q30);
		for (j = 1; j <= 16; j++) begin
			term = rpr_udiv((term * y) >> 30, j);
			if (j[0]) sum = sum - longint'(term);
			else      sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		freq = (n >= 63) ? 64'd0 : (64'(sum) >> n);
		return 32'(rpr_udiv(freq << 31, 64'(TWO_PI_Q29)));
	endfunction

endpackage

FILE: sv/rpr_sincos.sv
// Pipelined Taylor sine and cosine of a phase given in turns
module rpr_sincos #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [31:0]         phase,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_vld,
	output logic signed [31:0]  cos_o,
	output logic signed [31:0]  sin_o,
	output logic [SIDE_W-1:0]   side_out
);
	import rpr_pkg::*;

	function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v < 33'sd0)                     r = 32'sd0;
		else if (v > $signed({2'b00, ONE_Q30})) r = $signed({1'b0, ONE_Q30});
		else                                r = v[31:0];
		return r;
	endfunction

	logic              vld_s1, vld_s2, vld_s3;
	rpr_trig_t         trig_s1, trig_s2;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic signed [31:0] cos_s3, sin_s3;

	// quadrant split and fold to at most an eighth of a turn
	logic [29:0] rem_turn, fold_ang;
	logic        fold_nx;
	assign rem_turn = phase[29:0];
	assign fold_nx  = rem_turn > 30'h2000_0000;
	assign fold_ang = fold_nx ? 30'(31'h4000_0000 - {1'b0, rem_turn}) : rem_turn;

	// turns to Q30 radians
	logic [61:0] ang_prod;
	assign ang_prod = 62'(trig_s1.ang) * 62'(TWO_PI_Q29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s1 <= '{quad: phase[31:30], fold: fold_nx, ang: fold_ang, cs: '0, sn: '0};
			side_s1 <= side_in;
			trig_s2 <= '{quad: trig_s1.quad, fold: trig_s1.fold, ang: ang_prod[60:31],
				cs: $signed({2'b00, ONE_Q30}), sn: '0};
			side_s2 <= side_s1;
		end
	end

	// chain between the term sections
	logic              c_vld  [TRIG_TERMS+1];
	rpr_trig_t         c_trig [TRIG_TERMS+1];
	logic [SIDE_W-1:0] c_side [TRIG_TERMS+1];
	logic [30:0]       c_term [TRIG_TERMS+1];

	assign c_vld[0]  = vld_s2;
	assign c_trig[0] = trig_s2;
	assign c_side[0] = side_s2;
	assign c_term[0] = ONE_Q30;

	// one section per Taylor term: multiply, reciprocal divide, correct and sum
	for (genvar gi = 1; gi <= TRIG_TERMS; gi++) begin : g_term
		localparam int          J     = gi;
		localparam int          PH    = gi % 4;
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / J);

		logic              tv_s1, tv_s2, tv_s3;
		rpr_trig_t         tt_s1, tt_s2, tt_s3;
		logic [SIDE_W-1:0] ts_s1, ts_s2, ts_s3;
		logic [29:0]       prod_s1, prod_s2, quo_s2;
		logic [30:0]       term_s3;

		logic [60:0]       prod_a;
		logic [61:0]       prod_b;
		logic [29:0]       quo_nx;
		logic [34:0]       quo_j, rem;
		logic [29:0]       quo_fix;
		logic signed [32:0] term_sx;
		rpr_trig_t         trig_nx;

		assign prod_a = 61'(c_term[gi-1]) * 61'(c_trig[gi-1].ang);
		assign prod_b = 62'(prod_s1) * 62'(RECIP);
		assign quo_nx = (J == 1) ? prod_s1 : prod_b[61:32];

		// estimate is low by at most one
		assign quo_j   = 35'(quo_s2) * 35'(J);
		assign rem     = 35'(prod_s2) - quo_j;
		assign quo_fix = (rem >= 35'(J)) ? quo_s2 + 30'd1 : quo_s2;
		assign term_sx = $signed({3'b000, quo_fix});

		always_comb begin
			trig_nx = tt_s2;
			case (PH)
				1:       trig_nx.sn = tt_s2.sn + term_sx;
				2:       trig_nx.cs = tt_s2.cs - term_sx;
				3:       trig_nx.sn = tt_s2.sn - term_sx;
				default: trig_nx.cs = tt_s2.cs + term_sx;
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tv_s1 <= 1'b0;
				tv_s2 <= 1'b0;
				tv_s3 <= 1'b0;
			end else if (en) begin
				tv_s1 <= c_vld[gi-1];
				tv_s2 <= tv_s1;
				tv_s3 <= tv_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tt_s1   <= c_trig[gi-1];
				ts_s1   <= c_side[gi-1];
				prod_s1 <= prod_a[59:30];
				tt_s2   <= tt_s1;
				ts_s2   <= ts_s1;
				prod_s2 <= prod_s1;
				quo_s2  <= quo_nx;
				tt_s3   <= trig_nx;
				ts_s3   <= ts_s2;
				term_s3 <= {1'b0, quo_fix};
			end
		end

		assign c_vld[gi]  = tv_s3;
		assign c_trig[gi] = tt_s3;
		assign c_side[gi] = ts_s3;
		assign c_term[gi] = term_s3;
	end

	// clamp, undo the fold and place in the quadrant
	rpr_trig_t          t_end;
	logic signed [31:0] cs_cl, sn_cl, cs_f, sn_f, cos_nx, sin_nx;
	assign t_end = c_trig[TRIG_TERMS];
	assign cs_cl = clamp_unit(t_end.cs);
	assign sn_cl = clamp_unit(t_end.sn);
	assign cs_f  = t_end.fold ? sn_cl : cs_cl;
	assign sn_f  = t_end.fold ? cs_cl : sn_cl;

	always_comb begin
		case (t_end.quad)
			2'd0: begin
				cos_nx = cs_f;
				sin_nx = sn_f;
			end
			2'd1: begin
				cos_nx = -sn_f;
				sin_nx = cs_f;
			end
			2'd2: begin
				cos_nx = -cs_f;
				sin_nx = -sn_f;
			end
			default: begin
				cos_nx = sn_f;
				sin_nx = -cs_f;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= c_vld[TRIG_TERMS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s3  <= cos_nx;
			sin_s3  <= sin_nx;
			side_s3 <= c_side[TRIG_TERMS];
		end
	end

	assign out_vld  = vld_s3;
	assign cos_o    = cos_s3;
	assign sin_o    = sin_s3;
	assign side_out = side_s3;

endmodule

FILE: sv/rpr_rotate.sv
// Two-stage rotation of one Q16.16 pair with rounding and saturation
module rpr_rotate (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] ev,
	input  logic signed [31:0] ov,
	input  logic signed [31:0] cv,
	input  logic signed [31:0] sv,
	output logic signed [31:0] ev_rot,
	output logic signed [31:0] ov_rot
);
	import rpr_pkg::*;

	function automatic logic signed [31:0] round_sat(input logic signed [64:0] x);
		logic signed [64:0] sh;
		logic signed [31:0] r;
		sh = (x + 65'sd536870912) >>> 30;
		if (sh > 65'sd2147483647)       r = 32'sh7FFF_FFFF;
		else if (sh < -65'sd2147483648) r = 32'sh8000_0000;
		else                            r = sh[31:0];
		return r;
	endfunction

	logic signed [63:0] ec_s1, os_s1, es_s1, oc_s1;
	logic signed [31:0] er_s2, or_s2;

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			ec_s1 <= ev * cv;
			os_s1 <= ov * sv;
			es_s1 <= ev * sv;
			oc_s1 <= ov * cv;
		end
	end

	// combine, round half up, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			er_s2 <= round_sat(65'(ec_s1) - 65'(os_s1));
			or_s2 <= round_sat(65'(es_s1) + 65'(oc_s1));
		end
	end

	assign ev_rot = er_s2;
	assign ov_rot = or_s2;

endmodule

FILE: sv/rope_pair_rotator_unit.sv
// Rotary position encoding of one query/key element pair per word
// Use: an input word on s_* carries pair_index, position and the query and key
// pairs; one output word on m_* returns the rotated pairs and key_rotated.
// cfg_we/cfg_wdata write key_width; write only while the block is empty.
// The pipeline has four front stages (pair mod head size, frequency
// table, phase multiply), 45 in the sine/cosine unit (two for the angle,
// three per Taylor term over 14 terms, one for sign and order) and two for
// the rotation multiply and rounding.
// Throughput is one word per cycle; every stage moves together on one enable.
// When m_tready is low with a word waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets key_width to 4096.
module rope_pair_rotator_unit #(
	parameter int HEAD_DIM = 128,
	parameter int MAX_DIM  = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [12:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pair_index[10:0], position[22:11], query_even[54:23], query_odd[86:55],
	// key_even[118:87], key_odd[150:119], zero pad [151]
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// query_even_rot[31:0], query_odd_rot[63:32], key_even_rot[95:64],
	// key_odd_rot[127:96]
	output logic [127:0] m_tdata,
	// key_rotated[0]
	output logic [0:0]   m_tuser
);
	`include "rope_pair_rotator_unit_macros.svh"
	import rpr_pkg::*;

	localparam int                 KW        = $clog2(HEAD_DIM);
	localparam logic [23:0]        MOD_RECIP = 24'((1 << 24) / HEAD_DIM);
	localparam int                 SIDE_W    = $bits(rpr_side_t);
	localparam logic signed [31:0] TRIG_MAX  = 32'sd1073741824;

	logic en;
	logic [12:0] key_width_q;

	// key width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     key_width_q <= KEY_WIDTH_RST;
		else if (cfg_we) key_width_q <= cfg_wdata;
	end

	// frequency table in turns per position
	logic [31:0] rate_rom [HEAD_DIM];
	for (genvar gk = 0; gk < HEAD_DIM; gk++) begin : g_rom
		localparam logic [63:0] X    = (64'(gk) * LOG2_1E4_Q32) / 64'(HEAD_DIM);
		localparam logic [31:0] RATE = rpr_rate_of(X);
		assign rate_rom[gk] = RATE;
	end

	// input fields
	logic [11:0] idx_in;
	logic [13:0] kw_eff;
	rpr_side_t   side_in;
	assign idx_in       = {s_tdata[10:0], 1'b0};
	assign kw_eff       = ({1'b0, key_width_q} > 14'(MAX_DIM)) ? 14'(MAX_DIM)
	                                                          : {1'b0, key_width_q};
	assign side_in.krot = {2'b00, idx_in} < kw_eff;
	assign side_in.qe   = s_tdata[54:23];
	assign side_in.qo   = s_tdata[86:55];
	assign side_in.ke   = s_tdata[118:87];
	assign side_in.ko   = s_tdata[150:119];

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s6, vld_s7;
	rpr_side_t   side_s1, side_s2, side_s3, side_s4, side_s6, side_s7;
	logic [11:0] idx_s1, pos_s1, pos_s2, pos_s3, quo_s1;
	logic [KW-1:0] k_s2;
	logic [31:0] rate_s3, phase_s4;

	// quotient estimate of index over head size
	logic [35:0] quo_full;
	assign quo_full = 36'(idx_in) * 36'(MOD_RECIP);

	// remainder with one correction step
	logic [20:0] quo_h, rem_a, rem_b;
	assign quo_h = 21'(quo_s1) * 21'(HEAD_DIM);
	assign rem_a = 21'(idx_s1) - quo_h;
	assign rem_b = (rem_a >= 21'(HEAD_DIM)) ? rem_a - 21'(HEAD_DIM) : rem_a;

	// phase, wrapped to one turn
	logic [43:0] phase_full;
	assign phase_full = 44'(pos_s3) * 44'(rate_s3);

	assign en       = !vld_s7 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_in;
			idx_s1   <= idx_in;
			pos_s1   <= s_tdata[22:11];
			quo_s1   <= quo_full[35:24];
			side_s2  <= side_s1;
			pos_s2   <= pos_s1;
			k_s2     <= rem_b[KW-1:0];
			side_s3  <= side_s2;
			pos_s3   <= pos_s2;
			rate_s3  <= rate_rom[k_s2];
			side_s4  <= side_s3;
			phase_s4 <= phase_full[31:0];
		end
	end

	// sine and cosine
	logic               sc_vld;
	logic signed [31:0] sc_cos, sc_sin;
	logic [SIDE_W-1:0]  sc_side_w;
	rpr_side_t          sc_side;

	rpr_sincos #(
		.SIDE_W (SIDE_W)
	) u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.phase    (phase_s4),
		.side_in  (side_s4),
		.out_vld  (sc_vld),
		.cos_o    (sc_cos),
		.sin_o    (sc_sin),
		.side_out (sc_side_w)
	);
	assign sc_side = rpr_side_t'(sc_side_w);

	// rotation of both pairs
	logic signed [31:0] qe_rot, qo_rot, ke_rot, ko_rot;

	rpr_rotate u_rot_query (
		.clk    (clk),
		.en     (en),
		.ev     (sc_side.qe),
		.ov     (sc_side.qo),
		.cv     (sc_cos),
		.sv     (sc_sin),
		.ev_rot (qe_rot),
		.ov_rot (qo_rot)
	);

	rpr_rotate u_rot_key (
		.clk    (clk),
		.en     (en),
		.ev     (sc_side.ke),
		.ov     (sc_side.ko),
		.cv     (sc_cos),
		.sv     (sc_sin),
		.ev_rot (ke_rot),
		.ov_rot (ko_rot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sc_vld;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= sc_side;
			side_s7 <= side_s6;
		end
	end

	// output word, key passed through when not rotated
	assign m_tvalid        = vld_s7;
	assign m_tdata[31:0]   = qe_rot;
	assign m_tdata[63:32]  = qo_rot;
	assign m_tdata[95:64]  = side_s7.krot ? ke_rot : side_s7.ke;
	assign m_tdata[127:96] = side_s7.krot ? ko_rot : side_s7.ko;
	assign m_tuser[0]      = side_s7.krot;

	`RPR_ASSERT_NXT(a_hold_on_stall, !en, $stable(vld_s1) && $stable(vld_s7))
	`RPR_ASSERT_NXT(a_take_enters, s_tvalid && s_tready, vld_s1)
	`RPR_ASSERT_IMP(a_cos_range, sc_vld, (sc_cos <= TRIG_MAX) && (sc_cos >= -TRIG_MAX))
	`RPR_ASSERT_IMP(a_sin_range, sc_vld, (sc_sin <= TRIG_MAX) && (sc_sin >= -TRIG_MAX))

endmodule

FILE: test/tb_top.sv
// Testbench for the rotary position encoding pair rotator
`timescale 1ns / 100ps

module tb_top;
	import rpr_pkg::*;

	localparam int HEAD      = 128;
	localparam int DIM_CAP   = 4096;
	localparam int LAT       = 51;
	localparam int STALL_MAX = 20000;

	typedef struct packed {
		logic               krot;
		logic signed [31:0] ko;
		logic signed [31:0] ke;
		logic signed [31:0] qo;
		logic signed [31:0] qe;
	} rot_word_t;

	typedef struct {
		logic [10:0]        pair;
		logic [11:0]        pos;
		logic signed [31:0] qe, qo, ke, ko;
		logic               chk;   // typed-in result present
		rot_word_t          res;
	} dir_row_t;

	logic         clk, arst_n;
	logic         cfg_we;
	logic [12:0]  cfg_wdata;
	logic         s_tvalid, s_tready;
	logic [151:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;

	rope_pair_rotator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	rot_word_t rot_expected_q[$];
	logic [12:0] key_width_model;
	int errors = 0, words_out = 0, words_in = 0, key_rot_seen = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit recv_hold = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// phase rate for one pair, turns per position in Q0.32
	function automatic logic [31:0] turn_rate(input logic [10:0] pair);
		logic [7:0]      k;
		longint unsigned x, n, f, y, term, freq, j;
		longint          acc;
		k = 8'((32'(pair) * 2) % HEAD);
		x = longint'(k) * 64'd57070290109 / HEAD;
		n = x >> 32;
		f = x & 64'hFFFF_FFFF;
		y = (f * 64'd2977044472) >> 34;
		term = 64'd1073741824;
		acc = 64'sd1073741824;
		for (j = 1; j <= 16; j++) begin
			term = ((term * y) >> 30) / j;
			if (j[0]) acc -= longint'(term);
			else      acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sd1073741824) acc = 64'sd1073741824;
		freq = (n >= 63) ? 0 : (longint'(acc) >> n);
		return 32'((freq << 31) / 64'd3373259426);
	endfunction

	function automatic longint unit_clamp(input longint v);
		if (v < 0) return 0;
		if (v > 64'sd1073741824) return 64'sd1073741824;
		return v;
	endfunction

	// cosine and sine of a phase in turns, Q30
	function automatic void phase_trig(input logic [31:0] ph, output longint c,
			output longint s);
		longint unsigned r, at, a, term, j;
		longint cs, sn, tmp;
		bit fold;
		r = ph[29:0];
		fold = r > 64'h2000_0000;
		at = fold ? (64'h4000_0000 - r) : r;
		a = (at * 64'd3373259426) >> 31;
		term = 64'd1073741824;
		cs = 64'sd1073741824;
		sn = 0;
		for (j = 1; j <= 14; j++) begin
			term = ((term * a) >> 30) / j;
			case (j % 4)
				1: sn += longint'(term);
				2: cs -= longint'(term);
				3: sn -= longint'(term);
				default: cs += longint'(term);
			endcase
		end
		cs = unit_clamp(cs);
		sn = unit_clamp(sn);
		if (fold) begin
			tmp = cs; cs = sn; sn = tmp;
		end
		case (ph[31:30])
			2'd0: begin c = cs;  s = sn;  end
			2'd1: begin c = -sn; s = cs;  end
			2'd2: begin c = -cs; s = -sn; end
			default: begin c = sn; s = -cs; end
		endcase
	endfunction

	// round half up from Q30 and saturate to 32 bits
	function automatic logic [31:0] round_sat(input longint v);
		longint r;
		r = (v + 64'sd536870912) >>> 30;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic rot_word_t rotate_pair(input logic [10:0] pair, input logic [11:0] pos,
			input logic signed [31:0] qe, qo, ke, ko);
		rot_word_t w;
		longint c, s;
		logic [31:0] ph;
		logic [12:0] kw;
		ph = 32'(longint'(pos) * longint'(turn_rate(pair)));
		phase_trig(ph, c, s);
		kw = (key_width_model > DIM_CAP) ? 13'(DIM_CAP) : key_width_model;
		w.krot = (32'(pair) * 2) < kw;
		w.qe = round_sat(longint'(qe) * c - longint'(qo) * s);
		w.qo = round_sat(longint'(qe) * s + longint'(qo) * c);
		if (w.krot) begin
			w.ke = round_sat(longint'(ke) * c - longint'(ko) * s);
			w.ko = round_sat(longint'(ke) * s + longint'(ko) * c);
		end else begin
			w.ke = ke;
			w.ko = ko;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
		errors++;
		$display("MISMATCH word %0d %s: got %h expected %h", words_out, what, got, exp_v);
	endtask

	// send one word, waiting for acceptance
	task automatic send_pair(input logic [10:0] pair, input logic [11:0] pos,
			input logic signed [31:0] qe, qo, ke, ko, input bit has_res, input rot_word_t res);
		rot_word_t w;
		bit rdy;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		w = rotate_pair(pair, pos, qe, qo, ke, ko);
		if (has_res && w !== res) begin
			errors++;
			$display("MISMATCH typed-in result differs from prediction, pair %0d", pair);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, ko, ke, qo, qe, pos, pair};
		rot_expected_q.push_back(has_res ? res : w);
		// s_tready only moves at rising edges, so the falling edge shows the next one
		rdy = 1'b0;
		while (!rdy) begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end
		words_in++;
	endtask

	task automatic drain_wait();
		s_tvalid <= 1'b0;
		while (rot_expected_q.size() > 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_key_width(input logic [12:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_width_model = v;
	endtask

	task automatic random_pairs(input int cnt);
		logic signed [31:0] v[4];
		logic [10:0] pair;
		for (int i = 0; i < cnt; i++) begin
			for (int j = 0; j < 4; j++) begin
				case ($urandom_range(5, 0))
					0: v[j] = 32'sh7FFF_FFFF;
					1: v[j] = 32'sh8000_0000;
					2, 3: v[j] = $signed(32'($urandom_range(4 * 65536)) - 32'sd131072);
					default: v[j] = $urandom;
				endcase
			end
			pair = ($urandom_range(3, 0) == 0) ? 11'($urandom) : 11'($urandom_range(1100, 0));
			send_pair(pair, 12'($urandom), v[0], v[1], v[2], v[3], 0, '0);
		end
	endtask

	// receiver: ready with random gaps, compare against the oldest expectation
	always @(posedge clk) begin
		rot_word_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rot_expected_q.size() == 0) begin
					errors++;
					$display("MISMATCH word %0d arrived with nothing expected", words_out);
				end else begin
					e = rot_expected_q.pop_front();
					if (m_tdata[31:0] !== e.qe) report_mismatch("query_even_rot", m_tdata[31:0], e.qe);
					if (m_tdata[63:32] !== e.qo) report_mismatch("query_odd_rot", m_tdata[63:32], e.qo);
					if (m_tdata[95:64] !== e.ke) report_mismatch("key_even_rot", m_tdata[95:64], e.ke);
					if (m_tdata[127:96] !== e.ko) report_mismatch("key_odd_rot", m_tdata[127:96], e.ko);
					if (m_tuser[0] !== e.krot) report_mismatch("key_rotated", m_tuser, e.krot);
					key_rot_seen += e.krot;
				end
				words_out++;
			end
			m_tready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rot_expected_q.size() == 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	function automatic dir_row_t mk(input logic [10:0] pair, input logic [11:0] pos,
			input logic signed [31:0] qe, qo, ke, ko, input logic chk, input rot_word_t res);
		dir_row_t r;
		r.pair = pair; r.pos = pos; r.qe = qe; r.qo = qo; r.ke = ke; r.ko = ko;
		r.chk = chk; r.res = res;
		return r;
	endfunction

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_wdata = '0;
		s_tvalid = 0; s_tdata = '0;
		key_width_model = KEY_WIDTH_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// position 0 leaves values unchanged; all-zero inputs give all-zero outputs
		dir_rows.push_back(mk(0, 0, 32'sh10000, -32'sh10000, 32'sh7FFFFFFF, 32'sh80000000, 1,
			'{1'b1, 32'sh80000000, 32'sh7FFFFFFF, -32'sh10000, 32'sh10000}));
		dir_rows.push_back(mk(11'd2047, 0, 5, 6, 7, 8, 1, '{1'b1, 32'sd8, 32'sd7, 32'sd6, 32'sd5}));
		dir_rows.push_back(mk(0, 12'd4095, 0, 0, 0, 0, 1,
			'{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0}));
		dir_rows.push_back(mk(11'd2047, 12'd4095, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 0, '0));
		dir_rows.push_back(mk(1, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, '0));
		dir_rows.push_back(mk(63, 12'd4095, 32'sh80000000, 32'sh80000000, -1, -1, 0, '0));
		dir_rows.push_back(mk(64, 12'd2048, 32'sh10000, 0, 0, 32'sh10000, 0, '0));
		dir_rows.push_back(mk(11'd2047, 12'd2048, 32'sh10000, 0, 0, 32'sh10000, 0, '0));
		dir_rows.push_back(mk(11'd1023, 100, -32'sh10000, 32'sh12345, 1, -1, 0, '0));
		dir_rows.push_back(mk(11'd1024, 100, -32'sh10000, 32'sh12345, 1, -1, 0, '0));
		for (int p = 0; p < 8; p++)
			dir_rows.push_back(mk(11'(p), 12'(p * 512 + 7), 32'sh40000, -32'sh30000,
				32'sh20000, 32'sh55555, 0, '0));
		foreach (dir_rows[i])
			send_pair(dir_rows[i].pair, dir_rows[i].pos, dir_rows[i].qe, dir_rows[i].qo,
				dir_rows[i].ke, dir_rows[i].ko, dir_rows[i].chk, dir_rows[i].res);
		drain_wait();

		// key width extremes and in-between values, each with random traffic
		send_idle_pct = 17; recv_idle_pct = 55;
		write_key_width(13'd0);
		random_pairs(100);
		drain_wait();
		write_key_width(13'h1FFF);
		random_pairs(100);
		drain_wait();

		send_idle_pct = 55; recv_idle_pct = 17;
		write_key_width(13'd4097);
		random_pairs(150);
		drain_wait();
		write_key_width(13'd1);
		random_pairs(80);
		drain_wait();

		// long hold on the receiver so the pipeline fills and stalls
		send_idle_pct = 0; recv_idle_pct = 0;
		write_key_width(13'd1000);
		recv_hold = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			random_pairs(120);
		join
		drain_wait();

		write_key_width(13'($urandom_range(4096, 0)));
		random_pairs(200);
		drain_wait();
		write_key_width(13'd4096);
		random_pairs(180);
		drain_wait();

		$display("Covered %0d words in, %0d out, %0d with key rotated, across 8 key widths",
			words_in, words_out, key_rot_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
